[hdl/dbc_pkg.sv]
// ----------------------------------------------------------------------------
// Dalitz boundary check package
// Shared widths, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package dbc_pkg;

    localparam int MASS_W     = 32;
    localparam int TOTAL_W    = 34;
    localparam int KAL_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTHER = 3'd0,
        CFG_FIRST  = 3'd1,
        CFG_SECOND = 3'd2,
        CFG_THIRD  = 3'd3,
        CFG_TOTAL  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [MASS_W-1:0]  mother;
        logic [MASS_W-1:0]  first;
        logic [MASS_W-1:0]  second;
        logic [MASS_W-1:0]  third;
        logic [TOTAL_W-1:0] total;
    } dbc_cfg_t;

    typedef struct packed {
        logic [65:0] f1;
        logic [65:0] f2;
        logic [67:0] a13sq;
        logic [67:0] a23sq;
    } dbc_derived_t;

    typedef struct packed {
        logic               ok;
        logic [MASS_W-1:0]  m12;
        logic [MASS_W-1:0]  m13;
        logic signed [35:0] m23;
        logic [KAL_W-1:0]   v1;
        logic [KAL_W-1:0]   r1;
        logic [KAL_W-1:0]   v2;
        logic [KAL_W-1:0]   r2;
    } dbc_item_t;

endpackage

`default_nettype wire

[hdl/dbc_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Square root cell
// One bit of both floored square roots per cell, with the point carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_sqrt_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [4:0]        step_idx,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire dbc_pkg::dbc_item_t in_item,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dbc_pkg::dbc_item_t     out_item
);
    import dbc_pkg::*;

    function automatic logic [2*KAL_W-1:0] root_step(input logic [KAL_W-1:0] v,
                                                     input logic [KAL_W-1:0] r,
                                                     input logic [KAL_W-1:0] b);
        logic [KAL_W-1:0] t;
        begin
            t = r + b;
            if (v >= t)
            begin
                return {v - t, (r >> 1) + b};
            end
            return {v, r >> 1};
        end
    endfunction

    logic             valid_reg;
    dbc_item_t        item_reg;
    dbc_item_t        item_next;
    logic [6:0]       shamt;
    logic [KAL_W-1:0] bit_val;

    always_comb
    begin
        shamt     = 7'd62 - {1'b0, step_idx, 1'b0};
        bit_val   = {{(KAL_W-1){1'b0}}, 1'b1} << shamt[5:0];
        item_next = in_item;
        {item_next.v1, item_next.r1} = root_step(in_item.v1, in_item.r1, bit_val);
        {item_next.v2, item_next.r2} = root_step(in_item.v2, in_item.r2, bit_val);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[hdl/dbc_front.sv]
// ----------------------------------------------------------------------------
// Front stages
// Differences, their squares and the Kallen values that feed the root cells.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dbc_pkg::dbc_cfg_t     cfg,
    input  wire dbc_pkg::dbc_derived_t der,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [31:0]           m12,
    input  wire logic [31:0]           m13,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dbc_pkg::dbc_item_t         out_item
);
    import dbc_pkg::*;

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic               s1_ready, s2_ready, s3_ready;
    logic               s1_zero_reg, s2_zero_reg;
    logic [33:0]        s1_d1_reg, s1_d2_reg;
    logic [31:0]        s1_m12_reg, s1_m13_reg, s2_m12_reg, s2_m13_reg;
    logic signed [35:0] s1_m23_reg, s2_m23_reg;
    logic [67:0]        s2_d1sq_reg, s2_d2sq_reg;
    dbc_item_t          s3_item_reg;
    logic signed [34:0] d1, d2;
    logic signed [35:0] m23;
    logic               neg1, neg2;

    always_comb
    begin
        d1   = $signed({3'b0, m12}) - $signed({3'b0, cfg.first}) - $signed({3'b0, cfg.second});
        d2   = $signed({3'b0, m12}) - $signed({3'b0, cfg.mother}) - $signed({3'b0, cfg.third});
        m23  = $signed({2'b0, cfg.total}) - $signed({4'b0, m12}) - $signed({4'b0, m13});
        neg1 = s2_d1sq_reg < {2'b0, der.f1};
        neg2 = s2_d2sq_reg < {2'b0, der.f2};
    end

    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_zero_reg <= (m12 == '0);
            s1_d1_reg   <= d1[34] ? 34'(-d1) : d1[33:0];
            s1_d2_reg   <= d2[34] ? 34'(-d2) : d2[33:0];
            s1_m12_reg  <= m12;
            s1_m13_reg  <= m13;
            s1_m23_reg  <= m23;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_zero_reg <= s1_zero_reg;
            s2_d1sq_reg <= s1_d1_reg * s1_d1_reg;
            s2_d2sq_reg <= s1_d2_reg * s1_d2_reg;
            s2_m12_reg  <= s1_m12_reg;
            s2_m13_reg  <= s1_m13_reg;
            s2_m23_reg  <= s1_m23_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_item_reg.ok  <= !s2_zero_reg && !neg1 && !neg2;
            s3_item_reg.m12 <= s2_m12_reg;
            s3_item_reg.m13 <= s2_m13_reg;
            s3_item_reg.m23 <= s2_m23_reg;
            s3_item_reg.v1  <= s2_d1sq_reg[63:0] - der.f1[63:0];
            s3_item_reg.v2  <= s2_d2sq_reg[63:0] - der.f2[63:0];
            s3_item_reg.r1  <= '0;
            s3_item_reg.r2  <= '0;
        end
    end

endmodule

`default_nettype wire

[hdl/dbc_tail.sv]
// ----------------------------------------------------------------------------
// Tail stages
// Squares of the root sum and difference, the scaled products and the bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module dbc_tail (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dbc_pkg::dbc_derived_t der,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire dbc_pkg::dbc_item_t    in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       inside_flag
);
    import dbc_pkg::*;

    logic               t1_valid_reg, t2_valid_reg;
    logic               t1_ready, t2_ready;
    logic               t1_ok_reg, t1_neg_reg, inside_reg;
    logic [65:0]        t1_sum2_reg, t1_p13_reg;
    logic [63:0]        t1_dif2_reg;
    logic [68:0]        t1_p23_reg;
    logic [32:0]        sa;
    logic [31:0]        sd;
    logic [34:0]        m23m;
    logic [69:0]        sum2, dif2, p13, p23, a13, a23;
    logic               in13, in23;

    always_comb
    begin
        sa   = {1'b0, in_item.r1[31:0]} + {1'b0, in_item.r2[31:0]};
        sd   = (in_item.r1[31:0] >= in_item.r2[31:0]) ? in_item.r1[31:0] - in_item.r2[31:0]
                                                      : in_item.r2[31:0] - in_item.r1[31:0];
        m23m = in_item.m23[35] ? 35'(-in_item.m23) : in_item.m23[34:0];
        sum2 = {4'b0, t1_sum2_reg};
        dif2 = {6'b0, t1_dif2_reg};
        p13  = {4'b0, t1_p13_reg};
        p23  = {1'b0, t1_p23_reg};
        a13  = {2'b0, der.a13sq};
        a23  = {2'b0, der.a23sq};
        in13 = (p13 + sum2 > a13) && (p13 + dif2 < a13);
        if (t1_neg_reg)
        begin
            in23 = (sum2 > a23 + p23) && (dif2 < a23 + p23);
        end
        else
        begin
            in23 = (p23 + sum2 > a23) && (p23 + dif2 < a23);
        end
    end

    assign t2_ready    = !t2_valid_reg || out_ready;
    assign t1_ready    = !t1_valid_reg || t2_ready;
    assign in_ready    = t1_ready;
    assign out_valid   = t2_valid_reg;
    assign inside_flag = inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            if (t1_ready)
            begin
                t1_valid_reg <= in_valid;
            end
            if (t2_ready)
            begin
                t2_valid_reg <= t1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_ready && in_valid)
        begin
            t1_ok_reg   <= in_item.ok;
            t1_neg_reg  <= in_item.m23[35];
            t1_sum2_reg <= sa * sa;
            t1_dif2_reg <= sd * sd;
            t1_p13_reg  <= {({32'b0, in_item.m12} * {32'b0, in_item.m13}), 2'b00};
            t1_p23_reg  <= {({35'b0, in_item.m12} * {32'b0, m23m}), 2'b00};
        end
        if (t2_ready && t1_valid_reg)
        begin
            inside_reg <= t1_ok_reg && in13 && in23;
        end
    end

    a_sum_not_below_dif: assert property (@(posedge clk) disable iff (!rst_n)
        t1_valid_reg |-> ({2'b0, t1_sum2_reg} >= {4'b0, t1_dif2_reg}))
        else $error("root sum square below difference square");

    a_rejected_stays_out: assert property (@(posedge clk) disable iff (!rst_n)
        (t1_valid_reg && t2_ready && !t1_ok_reg) |=> !inside_reg)
        else $error("rejected point reported inside");

endmodule

`default_nettype wire

[hdl/dalitz_boundary_check_top.sv]
// ----------------------------------------------------------------------------
// Dalitz boundary check
// An accepted point passes the front stages, the root cells and the tail stages, all registered, to its result beat.
// Throughput: one point per cycle while out_ready does not stall the chain, set by the 32 root cells, each one stage.
// Reset clears the configuration registers and all stage valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dalitz_boundary_check_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [33:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] pair12_sq,
    input  wire logic [31:0] pair13_sq,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             inside_res
);
    import dbc_pkg::*;

    dbc_cfg_t           cfg_reg;
    dbc_derived_t       der_reg;
    logic signed [34:0] a13, a23;
    logic [33:0]        a13m, a23m;

    logic      chain_valid [0:SQRT_STEPS];
    logic      chain_ready [0:SQRT_STEPS];
    dbc_item_t chain_item  [0:SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MOTHER: cfg_reg.mother <= cfg_data[MASS_W-1:0];
                CFG_FIRST:  cfg_reg.first  <= cfg_data[MASS_W-1:0];
                CFG_SECOND: cfg_reg.second <= cfg_data[MASS_W-1:0];
                CFG_THIRD:  cfg_reg.third  <= cfg_data[MASS_W-1:0];
                CFG_TOTAL:  cfg_reg.total  <= cfg_data;
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        a13  = $signed({3'b0, cfg_reg.mother}) + $signed({3'b0, cfg_reg.first})
             - $signed({3'b0, cfg_reg.second}) - $signed({3'b0, cfg_reg.third});
        a23  = $signed({3'b0, cfg_reg.mother}) - $signed({3'b0, cfg_reg.first})
             + $signed({3'b0, cfg_reg.second}) - $signed({3'b0, cfg_reg.third});
        a13m = a13[34] ? 34'(-a13) : a13[33:0];
        a23m = a23[34] ? 34'(-a23) : a23[33:0];
    end

    always_ff @(posedge clk)
    begin
        der_reg.f1    <= {({32'b0, cfg_reg.first} * {32'b0, cfg_reg.second}), 2'b00};
        der_reg.f2    <= {({32'b0, cfg_reg.mother} * {32'b0, cfg_reg.third}), 2'b00};
        der_reg.a13sq <= a13m * a13m;
        der_reg.a23sq <= a23m * a23m;
    end

    dbc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .der       (der_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .m12       (pair12_sq),
        .m13       (pair13_sq),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_cell
        dbc_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_idx  (5'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    dbc_tail u_tail (
        .clk         (clk),
        .rst_n       (rst_n),
        .der         (der_reg),
        .in_valid    (chain_valid[SQRT_STEPS]),
        .in_ready    (chain_ready[SQRT_STEPS]),
        .in_item     (chain_item[SQRT_STEPS]),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .inside_flag (inside_res)
    );

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[SQRT_STEPS] |-> (chain_item[SQRT_STEPS].r1[63:32] == '0 &&
                                     chain_item[SQRT_STEPS].r2[63:32] == '0))
        else $error("square root wider than 32 bits");

endmodule

`default_nettype wire
